### sv/aont_pkg.sv
// aont_pkg: shared types, constants and the aes s-box for the package transform
// no dependencies
`timescale 1ns / 1ps

package aont_pkg;

    localparam int KEY_BYTES  = 16;
    localparam int BLOCK_BITS = 128;
    localparam int ROUNDS     = KEY_BYTES / 4 + 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYX,
        ST_ENC_KS,
        ST_ENC_TAG,
        ST_OUT_DATA,
        ST_OUT_TAG
    } aont_state_t;

    typedef struct packed {
        logic         start;
        logic [127:0] key;
        logic [127:0] block;
    } aes_req_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] block;
    } aes_rsp_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

### sv/aont_if.sv
// aont_in_if / aont_out_if: valid/ready channels for blocks and results
// depends on nothing
`timescale 1ns / 1ps

interface aont_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [63:0] rand_key_low;
    logic [63:0] rand_key_high;
    logic        first_block;
    logic        last_block;
    logic [4:0]  valid_bytes;
    modport source (output valid, data_low, data_high, rand_key_low, rand_key_high,
                    first_block, last_block, valid_bytes, input ready);
    modport sink (input valid, data_low, data_high, rand_key_low, rand_key_high,
                  first_block, last_block, valid_bytes, output ready);
endinterface

interface aont_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic        is_tag;
    logic        end_of_message;
    modport source (output valid, word_low, word_high, is_tag, end_of_message, input ready);
    modport sink (input valid, word_low, word_high, is_tag, end_of_message, output ready);
endinterface

### sv/aont_aes_core.sv
// aont_aes_core: aes-128 encryption, one byte of sub-bytes per cycle through a byte
// shift line, round key generated on the fly; depends on aont_pkg
`timescale 1ns / 1ps

module aont_aes_core
    import aont_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  aes_req_t req,
    output aes_rsp_t rsp
);

    // phases: sub-bytes over all 16 bytes, then the mix/key step
    logic [127:0] state_reg, state_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic [4:0]   byte_reg, byte_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [127:0] sr, mc, nk;
    logic [31:0]  tw;

    always_comb
    begin
        // shift rows on subbed state
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                sr[(c*4+i)*8 +: 8] = state_reg[((((c+i)&3)*4)+i)*8 +: 8];
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[(c*4)*8 +: 8];
            a1 = sr[(c*4+1)*8 +: 8];
            a2 = sr[(c*4+2)*8 +: 8];
            a3 = sr[(c*4+3)*8 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[(c*4)*8 +: 8]   = a0 ^ al ^ xt(a0 ^ a1);
            mc[(c*4+1)*8 +: 8] = a1 ^ al ^ xt(a1 ^ a2);
            mc[(c*4+2)*8 +: 8] = a2 ^ al ^ xt(a2 ^ a3);
            mc[(c*4+3)*8 +: 8] = a3 ^ al ^ xt(a3 ^ a0);
        end
        tw = {sbox(rk_reg[103:96]), sbox(rk_reg[127:120]), sbox(rk_reg[119:112]),
              sbox(rk_reg[111:104]) ^ rcon_reg};
        nk[31:0]   = rk_reg[31:0] ^ tw;
        nk[63:32]  = rk_reg[63:32] ^ nk[31:0];
        nk[95:64]  = rk_reg[95:64] ^ nk[63:32];
        nk[127:96] = rk_reg[127:96] ^ nk[95:64];
    end

    always_comb
    begin
        state_next = state_reg;
        rk_next    = rk_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        byte_next  = byte_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start && !busy_reg)
        begin
            state_next = req.block ^ req.key;
            rk_next    = req.key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            byte_next  = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (byte_reg != 5'd16)
            begin
                // rotate one byte through the s-box
                state_next = {sbox(state_reg[7:0]), state_reg[127:8]};
                byte_next  = byte_reg + 5'd1;
            end
            else
            begin
                state_next = ((round_reg == 4'(ROUNDS)) ? sr : mc) ^ nk;
                rk_next    = nk;
                rcon_next  = xt(rcon_reg);
                byte_next  = '0;
                if (round_reg == 4'(ROUNDS))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                round_next = round_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rk_reg    <= rk_next;
        rcon_reg  <= rcon_next;
        round_reg <= round_next;
        byte_reg  <= byte_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.block = state_reg;

endmodule

### sv/aes_all_or_nothing_transform.sv
// top level of the aes package transform: control, apb registers, tag accumulator
// depends on aont_pkg, aont_if and aont_aes_core
//
// channel | dir | payload
// blk_in  | in  | data, message key, first/last, valid_bytes
// res_out | out | word_low/high, is_tag, end_of_message
// apb     | in  | key_low at 0x0, key_high at 0x8
//
// each block takes two aes passes of 10 rounds each through the shared byte-serial
// s-box round unit; a last block adds a second result, the tag. reset clears
// control, counter and tag. a stalled output holds the unit; no input is taken
// until all results of a block left.
`timescale 1ns / 1ps

module aes_all_or_nothing_transform
    import aont_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aont_in_if.sink     blk_in,
    aont_out_if.source  res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    aont_state_t  st_reg, st_next;
    logic [BLOCK_BITS-1:0] fkey_reg, mkey_reg, mkey_next;
    logic [127:0] tag_reg, tag_next;
    logic [31:0]  idx_reg, idx_next;
    logic [127:0] pt_reg, pt_next;
    logic [127:0] res_reg, res_next;
    logic         last_reg, last_next;
    aes_req_t     req;
    aes_rsp_t     rsp;
    logic [127:0] ctr, din, ks, raw;
    logic         accept;

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3])
            1'b0:    prdata = fkey_reg[63:0];
            default: prdata = fkey_reg[127:64];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fkey_reg <= '0;
        else if (psel && penable && pwrite)
        begin
            if (!paddr[3])
                fkey_reg[63:0] <= pwdata;
            else
                fkey_reg[127:64] <= pwdata;
        end
    end

    aont_aes_core u_aes (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign accept = blk_in.valid && blk_in.ready;
    assign blk_in.ready = (st_reg == ST_IDLE);

    assign raw = {blk_in.data_high, blk_in.data_low};

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            din[i*8 +: 8] = (5'(i) < blk_in.valid_bytes) ? raw[i*8 +: 8] : 8'h00;
    end

    assign ks = rsp.block;

    always_comb
    begin
        st_next   = st_reg;
        mkey_next = mkey_reg;
        tag_next  = tag_reg;
        idx_next  = idx_reg;
        pt_next   = pt_reg;
        res_next  = res_reg;
        last_next = last_reg;
        ctr       = {96'd0, idx_reg};
        req       = '0;
        req.key   = mkey_reg;
        req.block = ctr;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pt_next   = din;
                    last_next = blk_in.last_block;
                    if (blk_in.first_block)
                    begin
                        mkey_next = {blk_in.rand_key_high, blk_in.rand_key_low};
                        idx_next  = '0;
                        tag_next  = {blk_in.rand_key_high, blk_in.rand_key_low};
                    end
                    st_next = ST_KEYX;
                end
            end
            ST_KEYX:
            begin
                req.start = 1'b1;
                st_next   = ST_ENC_KS;
            end
            ST_ENC_KS:
            begin
                if (rsp.done)
                begin
                    res_next  = pt_reg ^ ks;
                    req.start = 1'b1;
                    req.key   = fkey_reg;
                    req.block = pt_reg ^ ks ^ ctr;
                    st_next   = ST_ENC_TAG;
                end
            end
            ST_ENC_TAG:
            begin
                if (rsp.done)
                begin
                    tag_next = tag_reg ^ ks;
                    idx_next = idx_reg + 32'd1;
                    st_next  = ST_OUT_DATA;
                end
            end
            ST_OUT_DATA:
            begin
                if (res_out.ready)
                    st_next = last_reg ? ST_OUT_TAG : ST_IDLE;
            end
            ST_OUT_TAG:
            begin
                if (res_out.ready)
                begin
                    tag_next = '0;
                    idx_next = '0;
                    st_next  = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            tag_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            tag_reg <= tag_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mkey_reg <= mkey_next;
        pt_reg   <= pt_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign res_out.valid          = (st_reg == ST_OUT_DATA) || (st_reg == ST_OUT_TAG);
    assign res_out.is_tag         = (st_reg == ST_OUT_TAG);
    assign res_out.end_of_message = (st_reg == ST_OUT_TAG);
    assign res_out.word_low       = (st_reg == ST_OUT_TAG) ? tag_reg[63:0] : res_reg[63:0];
    assign res_out.word_high      = (st_reg == ST_OUT_TAG) ? tag_reg[127:64] : res_reg[127:64];

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.busy |-> !blk_in.ready) else $error("input taken while aes busy");
    a_tag_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT_TAG) |-> last_reg) else $error("tag without last block");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done) else $error("done held");

endmodule

### bench/tb_aes_all_or_nothing_transform.sv
// testbench for the aes package transform: random messages in, per-field result checks out
// depends on aont_if and the aes_all_or_nothing_transform rtl
`timescale 1ns / 1ps

module tb_aes_all_or_nothing_transform;

    localparam logic [3:0] ADDR_KEY_LOW  = 4'h0;
    localparam logic [3:0] ADDR_KEY_HIGH = 4'h8;
    localparam int         LIMIT_CYCLES  = 4000000;
    localparam int         SETTLE_CYCLES = 400;

    localparam logic [7:0] SUBST [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    typedef logic [7:0] sched_t [176];

    typedef struct {
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic [63:0] rand_key_low;
        logic [63:0] rand_key_high;
        logic        first_block;
        logic        last_block;
        logic [4:0]  valid_bytes;
    } block_req_t;

    typedef struct {
        logic [63:0] word_low;
        logic [63:0] word_high;
        logic        is_tag;
        logic        end_of_message;
    } word_res_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    aont_in_if  blk_in ();
    aont_out_if res_out ();

    aes_all_or_nothing_transform dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .blk_in  (blk_in.sink),
        .res_out (res_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    block_req_t  pending_blocks[$];
    word_res_t   expected_words[$];
    int          fail_count = 0;
    bit          calm = 0;
    longint      cycle_count = 0;

    // predictor state
    logic [63:0] fixed_key_low = '0;
    logic [63:0] fixed_key_high = '0;
    sched_t      fixed_sched;
    sched_t      msg_sched;
    logic [31:0] block_index = '0;
    logic [127:0] tag_acc = '0;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic void expand_key(input logic [127:0] key, output sched_t w);
        logic [7:0] t [4];
        logic [7:0] tmp;
        logic [7:0] rcon;
        rcon = 8'h01;
        for (int i = 0; i < 16; i++)
            w[i] = key[8*i +: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[i-4+j];
            if (i % 16 == 0)
            begin
                tmp = t[0];
                t[0] = SUBST[t[1]] ^ rcon;
                t[1] = SUBST[t[2]];
                t[2] = SUBST[t[3]];
                t[3] = SUBST[tmp];
                rcon = gf_double(rcon);
            end
            for (int j = 0; j < 4; j++)
                w[i+j] = w[i-16+j] ^ t[j];
        end
    endfunction

    function automatic logic [127:0] cipher_block(input sched_t w, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] n [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            s[i] = blk[8*i +: 8] ^ w[i];
        for (int rd = 1; rd <= 10; rd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    n[c*4+i] = SUBST[s[((c+i)&3)*4+i]];
            for (int c = 0; c < 4; c++)
            begin
                a0 = n[c*4]; a1 = n[c*4+1]; a2 = n[c*4+2]; a3 = n[c*4+3];
                if (rd < 10)
                begin
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[c*4]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    s[c*4+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    s[c*4+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    s[c*4+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
                else
                begin
                    s[c*4] = a0; s[c*4+1] = a1; s[c*4+2] = a2; s[c*4+3] = a3;
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = s[i] ^ w[16*rd + i];
        end
        for (int i = 0; i < 16; i++)
            r[8*i +: 8] = s[i];
        return r;
    endfunction

    // computes the transformed block (and tag on a last block) for one accepted request
    function automatic void transform_block(input block_req_t b);
        logic [127:0] ctr;
        logic [127:0] pt;
        logic [127:0] masked;
        int           nb;
        word_res_t    r;
        nb = (b.valid_bytes > 16) ? 16 : b.valid_bytes;
        if (b.first_block)
        begin
            expand_key({b.rand_key_high, b.rand_key_low}, msg_sched);
            block_index = '0;
            tag_acc = {b.rand_key_high, b.rand_key_low};
        end
        ctr = {96'd0, block_index};
        pt = {b.data_high, b.data_low};
        for (int i = 0; i < 16; i++)
            if (i >= nb)
                pt[8*i +: 8] = 8'h00;
        masked = pt ^ cipher_block(msg_sched, ctr);
        tag_acc = tag_acc ^ cipher_block(fixed_sched, masked ^ ctr);
        block_index = block_index + 32'd1;
        r.word_low = masked[63:0];
        r.word_high = masked[127:64];
        r.is_tag = 1'b0;
        r.end_of_message = 1'b0;
        expected_words.push_back(r);
        if (b.last_block)
        begin
            r.word_low = tag_acc[63:0];
            r.word_high = tag_acc[127:64];
            r.is_tag = 1'b1;
            r.end_of_message = 1'b1;
            expected_words.push_back(r);
            block_index = '0;
            tag_acc = '0;
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void queue_block(input logic [63:0] dl, input logic [63:0] dh,
                                        input logic [127:0] mkey, input logic first,
                                        input logic last, input logic [4:0] vb);
        block_req_t b;
        b.data_low = dl;
        b.data_high = dh;
        b.rand_key_low = mkey[63:0];
        b.rand_key_high = mkey[127:64];
        b.first_block = first;
        b.last_block = last;
        b.valid_bytes = vb;
        pending_blocks.push_back(b);
    endfunction

    // a message of nblk blocks; cont leaves out the first marker so the old message key stays
    function automatic void queue_message(input int nblk, input bit cont);
        logic [4:0] vb;
        logic [127:0] mkey;
        mkey = {rand64(), rand64()};
        for (int i = 0; i < nblk; i++)
        begin
            vb = 5'd16;
            if (i == nblk - 1 || $urandom_range(0, 7) == 0)
                vb = $urandom_range(1, 16);
            if ($urandom_range(0, 11) == 0)
                vb = $urandom_range(0, 31);
            queue_block(rand64(), rand64(), mkey, (i == 0) && !cont, i == nblk - 1, vb);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // request driver
    int         gap_left = 0;
    block_req_t cur_block;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (blk_in.valid && blk_in.ready)
                transform_block(cur_block);
            if (!blk_in.valid || blk_in.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    blk_in.valid <= 1'b0;
                end
                else if (pending_blocks.size() > 0 && !calm && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 3);
                    blk_in.valid <= 1'b0;
                end
                else if (pending_blocks.size() > 0)
                begin
                    cur_block = pending_blocks.pop_front();
                    blk_in.valid         <= 1'b1;
                    blk_in.data_low      <= cur_block.data_low;
                    blk_in.data_high     <= cur_block.data_high;
                    blk_in.rand_key_low  <= cur_block.rand_key_low;
                    blk_in.rand_key_high <= cur_block.rand_key_high;
                    blk_in.first_block   <= cur_block.first_block;
                    blk_in.last_block    <= cur_block.last_block;
                    blk_in.valid_bytes   <= cur_block.valid_bytes;
                end
                else
                    blk_in.valid <= 1'b0;
            end
        end
    end

    // result monitor
    int stall_left = 0;
    always @(posedge clk)
    begin
        word_res_t e;
        if (rst_n)
        begin
            if (res_out.valid && res_out.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result %h_%h tag %b eom %b", $time,
                             res_out.word_high, res_out.word_low, res_out.is_tag,
                             res_out.end_of_message);
                    fail_count++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (res_out.word_low !== e.word_low)
                    begin
                        $display("%0t: word_low expected %h actual %h", $time,
                                 e.word_low, res_out.word_low);
                        fail_count++;
                    end
                    if (res_out.word_high !== e.word_high)
                    begin
                        $display("%0t: word_high expected %h actual %h", $time,
                                 e.word_high, res_out.word_high);
                        fail_count++;
                    end
                    if (res_out.is_tag !== e.is_tag)
                    begin
                        $display("%0t: is_tag expected %b actual %b", $time,
                                 e.is_tag, res_out.is_tag);
                        fail_count++;
                    end
                    if (res_out.end_of_message !== e.end_of_message)
                    begin
                        $display("%0t: end_of_message expected %b actual %b", $time,
                                 e.end_of_message, res_out.end_of_message);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                res_out.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                res_out.ready <= 1'b0;
            end
            else
                res_out.ready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_KEY_LOW)
            fixed_key_low = value;
        else if (addr == ADDR_KEY_HIGH)
            fixed_key_high = value;
        expand_key({fixed_key_high, fixed_key_low}, fixed_sched);
    endtask

    task automatic drain();
        while (pending_blocks.size() > 0 || blk_in.valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int nitems);
        int queued;
        int len;
        queued = 0;
        queue_message($urandom_range(1, 4), 0);
        while (queued < nitems)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
            // a message without its first marker reuses the previous message key
            queue_message(len, $urandom_range(0, 9) == 0);
            queued += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        blk_in.valid = 1'b0;
        blk_in.data_low = '0;
        blk_in.data_high = '0;
        blk_in.rand_key_low = '0;
        blk_in.rand_key_high = '0;
        blk_in.first_block = 1'b0;
        blk_in.last_block = 1'b0;
        blk_in.valid_bytes = 5'd16;
        res_out.ready = 1'b0;
        expand_key(128'd0, fixed_sched);
        expand_key(128'd0, msg_sched);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset key, field extremes and the padding corners
        queue_block('1, '1, '1, 1, 1, 5'd16);
        queue_block('0, '0, '0, 1, 1, 5'd16);
        queue_block('1, '1, {rand64(), rand64()}, 1, 0, 5'd0);
        queue_block('1, '1, '0, 0, 0, 5'd1);
        queue_block('1, '1, '0, 0, 0, 5'd31);
        queue_block('1, '1, '0, 0, 0, 5'd17);
        queue_block(rand64(), rand64(), '0, 0, 1, 5'd15);
        // continuing after a last block: same message key, tag from zero
        queue_block(rand64(), rand64(), '1, 0, 0, 5'd8);
        queue_block(rand64(), rand64(), '1, 0, 1, 5'd16);
        queue_block(rand64(), rand64(), '1, 1, 1, 5'd9);
        drain();

        reg_write(ADDR_KEY_LOW, '1);
        reg_write(ADDR_KEY_HIGH, '1);
        queue_block('1, '1, '1, 1, 0, 5'd16);
        queue_block('0, '0, '0, 0, 0, 5'd16);
        queue_block('1, '0, '0, 0, 1, 5'd7);
        queue_block(rand64(), rand64(), '0, 1, 1, 5'd31);
        random_phase(200);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(ADDR_KEY_LOW, rand64());
            reg_write(ADDR_KEY_HIGH, rand64());
            if (ph == 3)
                calm = 1;
            random_phase(200);
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
